### src/pcj_pkg.sv
// Package for the polyline corner join unit: word types, widths, micro-op codes
// and the fixed micro-program that the sequencer runs for one corner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcj_pkg;

    localparam int COORD_W    = 32;
    // Wide enough for d*d, the largest exact product of the corner test.
    localparam int WIDE_W     = 4 * COORD_W + 16;
    localparam int JOIN_SHIFT = 4;   // times 16, the join ratio squared
    localparam int STEP_W     = 6;
    localparam int CNT_W      = $clog2(WIDE_W);

    localparam logic [WIDE_W-1:0] SAT_POS =
        {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic [WIDE_W-1:0] SAT_NEG =
        {{(WIDE_W-COORD_W){1'b0}}, 1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] begin_x;
        logic signed [COORD_W-1:0] begin_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      first_segment;
        logic                      last_segment;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BRZ, OP_SPAN, OP_JOIN
    } t_op;

    typedef enum logic [4:0] {
        R_X1, R_Y1, R_X2, R_Y2, R_X3, R_Y3, R_X4, R_Y4,
        R_DX12, R_DY12, R_DX34, R_DY34, R_C, R_A, R_B,
        R_P, R_Q, R_P16, R_IX, R_IY, R_CA, R_CB
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg a;
        t_reg b;
        t_reg dst;
    } t_uop;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(42);

    // Corner program: determinants, two rounded divisions, span test,
    // then the exact squared-distance join test.
    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        case (step)
            6'd0:    return '{OP_SUB,  R_X1,   R_X2,   R_DX12};
            6'd1:    return '{OP_SUB,  R_Y1,   R_Y2,   R_DY12};
            6'd2:    return '{OP_SUB,  R_X3,   R_X4,   R_DX34};
            6'd3:    return '{OP_SUB,  R_Y3,   R_Y4,   R_DY34};
            6'd4:    return '{OP_MUL,  R_DX12, R_DY34, R_P};
            6'd5:    return '{OP_MUL,  R_DY12, R_DX34, R_Q};
            6'd6:    return '{OP_SUB,  R_P,    R_Q,    R_C};
            6'd7:    return '{OP_BRZ,  R_C,    R_C,    R_C};
            6'd8:    return '{OP_MUL,  R_X1,   R_Y2,   R_P};
            6'd9:    return '{OP_MUL,  R_Y1,   R_X2,   R_Q};
            6'd10:   return '{OP_SUB,  R_P,    R_Q,    R_A};
            6'd11:   return '{OP_MUL,  R_X3,   R_Y4,   R_P};
            6'd12:   return '{OP_MUL,  R_Y3,   R_X4,   R_Q};
            6'd13:   return '{OP_SUB,  R_P,    R_Q,    R_B};
            6'd14:   return '{OP_MUL,  R_A,    R_DX34, R_P};
            6'd15:   return '{OP_MUL,  R_DX12, R_B,    R_Q};
            6'd16:   return '{OP_SUB,  R_P,    R_Q,    R_P};
            6'd17:   return '{OP_DIV,  R_P,    R_C,    R_IX};
            6'd18:   return '{OP_MUL,  R_A,    R_DY34, R_P};
            6'd19:   return '{OP_MUL,  R_DY12, R_B,    R_Q};
            6'd20:   return '{OP_SUB,  R_P,    R_Q,    R_P};
            6'd21:   return '{OP_DIV,  R_P,    R_C,    R_IY};
            6'd22:   return '{OP_SPAN, R_IX,   R_IY,   R_IX};
            6'd23:   return '{OP_SUB,  R_IX,   R_X2,   R_P};
            6'd24:   return '{OP_MUL,  R_P,    R_P,    R_P};
            6'd25:   return '{OP_SUB,  R_IY,   R_Y2,   R_Q};
            6'd26:   return '{OP_MUL,  R_Q,    R_Q,    R_Q};
            6'd27:   return '{OP_ADD,  R_P,    R_Q,    R_CA};
            6'd28:   return '{OP_SUB,  R_IX,   R_X3,   R_P};
            6'd29:   return '{OP_MUL,  R_P,    R_P,    R_P};
            6'd30:   return '{OP_SUB,  R_IY,   R_Y3,   R_Q};
            6'd31:   return '{OP_MUL,  R_Q,    R_Q,    R_Q};
            6'd32:   return '{OP_ADD,  R_P,    R_Q,    R_CB};
            6'd33:   return '{OP_SUB,  R_X2,   R_X3,   R_P};
            6'd34:   return '{OP_MUL,  R_P,    R_P,    R_P};
            6'd35:   return '{OP_SUB,  R_Y2,   R_Y3,   R_Q};
            6'd36:   return '{OP_MUL,  R_Q,    R_Q,    R_Q};
            6'd37:   return '{OP_ADD,  R_P,    R_Q,    R_P};
            6'd38:   return '{OP_SUB,  R_P16,  R_CA,   R_P};
            6'd39:   return '{OP_SUB,  R_P,    R_CB,   R_P};
            6'd40:   return '{OP_MUL,  R_CA,   R_CB,   R_Q};
            6'd41:   return '{OP_MUL,  R_P,    R_P,    R_CA};
            default: return '{OP_JOIN, R_P,    R_Q,    R_CA};
        endcase
    endfunction

endpackage

`default_nettype wire

### src/polyline_corner_join_unit.sv
// Polyline corner join: top level with micro-sequencer, shared shift-add
// multiplier / restoring divider and the output word register.
// Depends on pcj_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: i_valid / i_word, o_stall. One word is one path segment.
//   Output channel: o_valid / o_word, i_stall. One word is one path vertex;
//   last_point marks the final vertex a segment causes (1 to 3 per segment).
//   The block takes one segment at a time; o_stall is high from acceptance
//   until the last vertex of that segment is loaded into the output register.
//   A first segment goes straight to the output state. A later segment runs
//   the corner program of 43 sequencer steps, among them 18 multiplies on
//   the shift-add multiplier and two divisions on the divider, which makes
//   one quotient bit per cycle. Parallel lines leave after the eighth step.
//   The next segment is accepted the cycle after the last vertex loads.
//   A stalled output word holds; the block loads the next vertex only when
//   the output register is empty or being taken.
//   Reset (synchronous, i_rst_n low) clears the sequencer and the output
//   valid, and the kept previous segment reads as all zero.
module polyline_corner_join_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire pcj_pkg::t_in_word i_word,
    output logic                 o_valid,
    input  wire                  i_stall,
    output pcj_pkg::t_out_word   o_word
);

    localparam int W  = pcj_pkg::COORD_W;
    localparam int WW = pcj_pkg::WIDE_W;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_MUL, S_DIV, S_OUT} t_state;
    typedef enum logic [1:0] {K_BEGIN, K_ISECT, K_ENDS} t_kind;

    function automatic logic [WW-1:0] f_sx(input logic [W-1:0] v);
        return {{(WW-W){v[W-1]}}, v};
    endfunction

    function automatic logic [WW-1:0] f_abs(input logic [WW-1:0] v);
        return v[WW-1] ? -v : v;
    endfunction

    function automatic logic f_in_span(input logic signed [W-1:0] v,
                                       input logic signed [W-1:0] e1,
                                       input logic signed [W-1:0] e2);
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        lo = (e1 <= e2) ? e1 : e2;
        hi = (e1 <= e2) ? e2 : e1;
        return (lo <= v) && (v <= hi);
    endfunction

    t_state r_state;
    t_kind  r_kind;
    logic [pcj_pkg::STEP_W-1:0] r_step;
    logic [pcj_pkg::CNT_W-1:0]  r_cnt;
    logic [1:0]                 r_oidx;
    logic                       r_last;
    logic                       r_neg;
    logic                       r_ovalid;
    pcj_pkg::t_out_word         r_oword;

    logic [W-1:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3, r_x4, r_y4;
    logic [WW-1:0] r_dx12, r_dy12, r_dx34, r_dy34, r_c, r_a, r_b;
    logic [WW-1:0] r_p, r_q, r_ix, r_iy, r_ca, r_cb;
    logic [WW-1:0] r_acc, r_sh, r_mr;

    pcj_pkg::t_uop n_uop;
    pcj_pkg::t_uop n_prev_uop;
    logic [WW-1:0] n_opa, n_opb;
    logic [WW-1:0] n_rem2, n_rem, n_quo, n_sat, n_div_res, n_mul_res;
    logic          n_ge;
    logic          n_span;
    logic          n_join;
    logic [1:0]    n_total;
    logic          n_load;
    logic [W-1:0]  n_px, n_py;

    assign n_uop = pcj_pkg::f_uop(r_step);
    // destination belongs to the op just stepped past
    assign n_prev_uop = pcj_pkg::f_uop(r_step - 1'b1);

    always_comb begin
        case (n_uop.a)
            pcj_pkg::R_X1:   n_opa = f_sx(r_x1);
            pcj_pkg::R_Y1:   n_opa = f_sx(r_y1);
            pcj_pkg::R_X2:   n_opa = f_sx(r_x2);
            pcj_pkg::R_Y2:   n_opa = f_sx(r_y2);
            pcj_pkg::R_X3:   n_opa = f_sx(r_x3);
            pcj_pkg::R_Y3:   n_opa = f_sx(r_y3);
            pcj_pkg::R_X4:   n_opa = f_sx(r_x4);
            pcj_pkg::R_Y4:   n_opa = f_sx(r_y4);
            pcj_pkg::R_DX12: n_opa = r_dx12;
            pcj_pkg::R_DY12: n_opa = r_dy12;
            pcj_pkg::R_DX34: n_opa = r_dx34;
            pcj_pkg::R_DY34: n_opa = r_dy34;
            pcj_pkg::R_C:    n_opa = r_c;
            pcj_pkg::R_A:    n_opa = r_a;
            pcj_pkg::R_B:    n_opa = r_b;
            pcj_pkg::R_P:    n_opa = r_p;
            pcj_pkg::R_Q:    n_opa = r_q;
            pcj_pkg::R_P16:  n_opa = r_p << pcj_pkg::JOIN_SHIFT;
            pcj_pkg::R_IX:   n_opa = r_ix;
            pcj_pkg::R_IY:   n_opa = r_iy;
            pcj_pkg::R_CA:   n_opa = r_ca;
            pcj_pkg::R_CB:   n_opa = r_cb;
            default:         n_opa = '0;
        endcase
    end

    always_comb begin
        case (n_uop.b)
            pcj_pkg::R_X1:   n_opb = f_sx(r_x1);
            pcj_pkg::R_Y1:   n_opb = f_sx(r_y1);
            pcj_pkg::R_X2:   n_opb = f_sx(r_x2);
            pcj_pkg::R_Y2:   n_opb = f_sx(r_y2);
            pcj_pkg::R_X3:   n_opb = f_sx(r_x3);
            pcj_pkg::R_Y3:   n_opb = f_sx(r_y3);
            pcj_pkg::R_X4:   n_opb = f_sx(r_x4);
            pcj_pkg::R_Y4:   n_opb = f_sx(r_y4);
            pcj_pkg::R_DX12: n_opb = r_dx12;
            pcj_pkg::R_DY12: n_opb = r_dy12;
            pcj_pkg::R_DX34: n_opb = r_dx34;
            pcj_pkg::R_DY34: n_opb = r_dy34;
            pcj_pkg::R_C:    n_opb = r_c;
            pcj_pkg::R_A:    n_opb = r_a;
            pcj_pkg::R_B:    n_opb = r_b;
            pcj_pkg::R_P:    n_opb = r_p;
            pcj_pkg::R_Q:    n_opb = r_q;
            pcj_pkg::R_P16:  n_opb = r_p << pcj_pkg::JOIN_SHIFT;
            pcj_pkg::R_IX:   n_opb = r_ix;
            pcj_pkg::R_IY:   n_opb = r_iy;
            pcj_pkg::R_CA:   n_opb = r_ca;
            pcj_pkg::R_CB:   n_opb = r_cb;
            default:         n_opb = '0;
        endcase
    end

    // One restoring division step: remainder in r_acc, dividend shifts out
    // of r_mr while quotient bits shift in behind it.
    always_comb begin
        n_rem2    = {r_acc[WW-2:0], r_mr[WW-1]};
        n_ge      = (n_rem2 >= r_sh);
        n_rem     = n_ge ? (n_rem2 - r_sh) : n_rem2;
        n_quo     = {r_mr[WW-2:0], n_ge};
        if (r_neg) begin
            n_sat = (n_quo > pcj_pkg::SAT_NEG) ? pcj_pkg::SAT_NEG : n_quo;
        end else begin
            n_sat = (n_quo > pcj_pkg::SAT_POS) ? pcj_pkg::SAT_POS : n_quo;
        end
        n_div_res = r_neg ? -n_sat : n_sat;
        n_mul_res = r_neg ? -r_acc : r_acc;
    end

    assign n_span = f_in_span(r_ix[W-1:0], r_x1, r_x2)
                 && f_in_span(r_iy[W-1:0], r_y1, r_y2)
                 && f_in_span(r_ix[W-1:0], r_x3, r_x4)
                 && f_in_span(r_iy[W-1:0], r_y3, r_y4);

    // p holds d, q holds ca*cb, ca holds d*d at the join decision
    assign n_join = !r_p[WW-1] && (r_p != '0) && ((r_q << 2) < r_ca);

    assign n_total = ((r_kind == K_ENDS) ? 2'd2 : 2'd1) + {1'b0, r_last};
    assign n_load  = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    always_comb begin
        if (r_oidx == 2'd0) begin
            case (r_kind)
                K_BEGIN: begin n_px = r_x3;          n_py = r_y3;          end
                K_ISECT: begin n_px = r_ix[W-1:0];   n_py = r_iy[W-1:0];   end
                default: begin n_px = r_x2;          n_py = r_y2;          end
            endcase
        end else if ((r_oidx == 2'd1) && (r_kind == K_ENDS)) begin
            n_px = r_x3;
            n_py = r_y3;
        end else begin
            n_px = r_x4;
            n_py = r_y4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_BEGIN;
            r_step   <= '0;
            r_cnt    <= '0;
            r_oidx   <= '0;
            r_last   <= 1'b0;
            r_neg    <= 1'b0;
            r_ovalid <= 1'b0;
            r_x1     <= '0;
            r_y1     <= '0;
            r_x2     <= '0;
            r_y2     <= '0;
        end else begin
            // drop the output word once taken, unless a new one loads below
            if (r_ovalid && !i_stall && !n_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x3   <= i_word.begin_x;
                        r_y3   <= i_word.begin_y;
                        r_x4   <= i_word.end_x;
                        r_y4   <= i_word.end_y;
                        r_last <= i_word.last_segment;
                        r_step <= '0;
                        r_oidx <= '0;
                        if (i_word.first_segment) begin
                            r_kind  <= K_BEGIN;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    case (n_uop.op)
                        pcj_pkg::OP_ADD, pcj_pkg::OP_SUB: begin
                            r_step <= r_step + 1'b1;
                            r_acc  <= (n_uop.op == pcj_pkg::OP_ADD) ?
                                      (n_opa + n_opb) : (n_opa - n_opb);
                            r_neg  <= 1'b0;
                            // write back through the multiplier finish path
                            r_mr   <= '0;
                            r_state <= S_MUL;
                        end
                        pcj_pkg::OP_MUL: begin
                            r_acc   <= '0;
                            r_sh    <= f_abs(n_opa);
                            r_mr    <= f_abs(n_opb);
                            r_neg   <= n_opa[WW-1] ^ n_opb[WW-1];
                            r_state <= S_MUL;
                            r_step  <= r_step + 1'b1;
                        end
                        pcj_pkg::OP_DIV: begin
                            r_acc   <= '0;
                            r_mr    <= (f_abs(n_opa) << 1) + f_abs(n_opb);
                            r_sh    <= f_abs(n_opb) << 1;
                            r_neg   <= n_opa[WW-1] ^ n_opb[WW-1];
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                            r_step  <= r_step + 1'b1;
                        end
                        pcj_pkg::OP_BRZ: begin
                            if (r_c == '0) begin
                                r_kind  <= K_ENDS;
                                r_state <= S_OUT;
                            end else begin
                                r_step <= r_step + 1'b1;
                            end
                        end
                        pcj_pkg::OP_SPAN: begin
                            if (n_span) begin
                                r_kind  <= K_ISECT;
                                r_state <= S_OUT;
                            end else begin
                                r_step <= r_step + 1'b1;
                            end
                        end
                        default: begin
                            r_kind  <= n_join ? K_ISECT : K_ENDS;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_MUL: begin
                    if (r_mr == '0) begin
                        case (n_prev_uop.dst)
                            pcj_pkg::R_DX12: r_dx12 <= n_mul_res;
                            pcj_pkg::R_DY12: r_dy12 <= n_mul_res;
                            pcj_pkg::R_DX34: r_dx34 <= n_mul_res;
                            pcj_pkg::R_DY34: r_dy34 <= n_mul_res;
                            pcj_pkg::R_C:    r_c    <= n_mul_res;
                            pcj_pkg::R_A:    r_a    <= n_mul_res;
                            pcj_pkg::R_B:    r_b    <= n_mul_res;
                            pcj_pkg::R_Q:    r_q    <= n_mul_res;
                            pcj_pkg::R_CA:   r_ca   <= n_mul_res;
                            pcj_pkg::R_CB:   r_cb   <= n_mul_res;
                            default:         r_p    <= n_mul_res;
                        endcase
                        r_state <= S_FETCH;
                    end else begin
                        if (r_mr[0]) begin
                            r_acc <= r_acc + r_sh;
                        end
                        r_sh <= r_sh << 1;
                        r_mr <= r_mr >> 1;
                    end
                end
                S_DIV: begin
                    r_acc <= n_rem;
                    r_mr  <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == pcj_pkg::CNT_W'(WW - 1)) begin
                        if (n_prev_uop.dst == pcj_pkg::R_IY) begin
                            r_iy <= n_div_res;
                        end else begin
                            r_ix <= n_div_res;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_OUT: begin
                    if (n_load) begin
                        r_ovalid           <= 1'b1;
                        r_oword.point_x    <= n_px;
                        r_oword.point_y    <= n_py;
                        r_oword.last_point <= (r_oidx == n_total - 2'd1);
                        r_oidx             <= r_oidx + 2'd1;
                        if (r_oidx == n_total - 2'd1) begin
                            // keep this segment for the next corner
                            r_x1    <= r_x3;
                            r_y1    <= r_y3;
                            r_x2    <= r_x4;
                            r_y2    <= r_y4;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a segment");

    a_oidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_oidx < n_total))
        else $error("output index past the vertex count");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_step <= pcj_pkg::LAST_STEP))
        else $error("sequencer step out of program");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |=> o_valid)
        else $error("loaded vertex not presented");
`endif

endmodule

`default_nettype wire
